### hdl/imab_pkg.sv
package imab_pkg;

    localparam logic [6:0] IndexMax = 7'd88;
    localparam logic [15:0] MinBlockLen = 16'd4;
    localparam logic signed [17:0] PredMax = 18'sd32767;
    localparam logic signed [17:0] PredMin = -18'sd32768;

    localparam logic [14:0] STEP_TABLE [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
        15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
        15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
        15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
        15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
        15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
        15'd29794, 15'd32767
    };

    localparam logic signed [4:0] INDEX_MOVE [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    typedef struct packed {
        logic signed [15:0] sample;
        logic               end_of_block;
        logic               bad_index;
        logic               end_of_run;
    } res_t;

endpackage

### hdl/imab_nibble.sv
module imab_nibble (
    input  logic signed [15:0] pred,
    input  logic [6:0]         idx,
    input  logic [3:0]         code,
    output logic signed [15:0] pred_next,
    output logic [6:0]         idx_next
);
    import imab_pkg::*;

    logic [6:0]         idx_c;
    logic [14:0]        step;
    logic [16:0]        delta;
    logic signed [17:0] sum;
    logic signed [7:0]  ni;

    always_comb
    begin
        idx_c = (idx > IndexMax) ? IndexMax : idx;
        step  = STEP_TABLE[idx_c];
        delta = {2'b00, step >> 3};
        if (code[0])
        begin
            delta = delta + {2'b00, step >> 2};
        end
        if (code[1])
        begin
            delta = delta + {2'b00, step >> 1};
        end
        if (code[2])
        begin
            delta = delta + {2'b00, step};
        end
        if (code[3])
        begin
            sum = {{2{pred[15]}}, pred} - $signed({1'b0, delta});
        end
        else
        begin
            sum = {{2{pred[15]}}, pred} + $signed({1'b0, delta});
        end
        if (sum > PredMax)
        begin
            pred_next = PredMax[15:0];
        end
        else if (sum < PredMin)
        begin
            pred_next = PredMin[15:0];
        end
        else
        begin
            pred_next = sum[15:0];
        end

        ni = $signed({1'b0, idx_c}) + {{3{INDEX_MOVE[code[2:0]][4]}}, INDEX_MOVE[code[2:0]]};
        if (ni < 8'sd0)
        begin
            idx_next = 7'd0;
        end
        else if (ni > $signed({1'b0, IndexMax}))
        begin
            idx_next = IndexMax;
        end
        else
        begin
            idx_next = ni[6:0];
        end
    end

endmodule

### hdl/imab_outbuf.sv
module imab_outbuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic [1:0]     load_cnt,
    input  imab_pkg::res_t load_r0,
    input  imab_pkg::res_t load_r1,
    input  logic           pop,
    output logic           can_load,
    output logic           head_valid,
    output imab_pkg::res_t head,
    output logic [1:0]     cnt
);
    import imab_pkg::*;

    res_t       s0_reg, s0_next;
    res_t       s1_reg, s1_next;
    logic [1:0] cnt_reg, cnt_next;

    // A new item may enter once the queue is empty or its last result leaves now.
    assign can_load   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = s0_reg;
    assign cnt        = cnt_reg;

    always_comb
    begin
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            s0_next  = load_r0;
            s1_next  = load_r1;
            cnt_next = load_cnt;
        end
        else if (pop)
        begin
            s0_next  = s1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
    end

endmodule

### hdl/ima_adpcm_block_decoder.sv
// Channel   Signals                                              Dir   Width
// in        in_valid, in_ready, data_byte, start_of_stream        in    8 + 1
// out       out_valid, out_ready, sample, end_of_block,           out   16 + 1 + 1 + 1
//           bad_index, end_of_run
// cfg       cfg_valid, cfg_ready, cfg_data (bytes_per_block)      in    16
//
// An item passes an input register, then combinational decode logic (two chained nibble
// updates) writes its results into a two-entry output queue. Header bytes give at most one
// result each, a data byte two; the single output port emits one result a cycle while
// out_ready is high. Reset clears the decoder state and sets block length to 256 bytes.
// Output stalls back up through the queue into the input register and then in_ready.
module ima_adpcm_block_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] sample,
    output logic        end_of_block,
    output logic        bad_index,
    output logic        end_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import imab_pkg::*;

    logic        ivalid_reg;
    logic [7:0]  idata_reg;
    logic        isos_reg;

    logic [15:0] bpb_reg;
    logic [15:0] pos_reg, pos_next;
    logic signed [15:0] pred_reg, pred_next;
    logic [6:0]  idx_reg, idx_next;
    logic [7:0]  hlow_reg, hlow_next;
    logic        err_reg, err_next;

    logic        take;
    logic        can_load;
    logic        pop;
    logic        head_valid;
    logic [1:0]  qcnt;
    res_t        head;
    res_t        r0, r1;
    logic [1:0]  nres;

    logic [15:0] len;
    logic [15:0] pos_eff;
    logic        err_eff;
    logic        last;

    logic signed [15:0] pred_a, pred_b;
    logic [6:0]  idx_a, idx_b;

    assign cfg_ready = 1'b1;
    assign pop       = head_valid && out_ready;
    assign take      = ivalid_reg && can_load;
    assign in_ready  = !ivalid_reg || can_load;

    assign out_valid    = head_valid;
    assign sample       = head.sample;
    assign end_of_block = head.end_of_block;
    assign bad_index    = head.bad_index;
    assign end_of_run   = head.end_of_run;

    imab_nibble u_nib_lo (
        .pred      (pred_reg),
        .idx       (idx_reg),
        .code      (idata_reg[3:0]),
        .pred_next (pred_a),
        .idx_next  (idx_a)
    );

    imab_nibble u_nib_hi (
        .pred      (pred_a),
        .idx       (idx_a),
        .code      (idata_reg[7:4]),
        .pred_next (pred_b),
        .idx_next  (idx_b)
    );

    always_comb
    begin
        len      = (bpb_reg < MinBlockLen) ? MinBlockLen : bpb_reg;
        pos_eff  = isos_reg ? 16'd0 : pos_reg;
        err_eff  = isos_reg ? 1'b0 : err_reg;
        last     = (pos_eff >= (len - 16'd1));
        pos_next = pos_eff;
        pred_next = pred_reg;
        idx_next = idx_reg;
        hlow_next = hlow_reg;
        err_next = err_eff;
        nres     = 2'd0;
        r0       = '0;
        r1       = '0;
        if (!err_eff)
        begin
            pos_next = last ? 16'd0 : (pos_eff + 16'd1);
            if (pos_eff == 16'd0)
            begin
                hlow_next = idata_reg;
            end
            else if (pos_eff == 16'd1)
            begin
                pred_next = $signed({idata_reg, hlow_reg});
            end
            else if (pos_eff == 16'd2)
            begin
                if (idata_reg > {1'b0, IndexMax})
                begin
                    r0.bad_index  = 1'b1;
                    r0.end_of_run = 1'b1;
                    err_next      = 1'b1;
                    pos_next      = 16'd0;
                end
                else
                begin
                    idx_next        = idata_reg[6:0];
                    r0.sample       = pred_reg;
                    r0.end_of_block = (len <= MinBlockLen);
                    r0.end_of_run   = 1'b1;
                end
                nres = 2'd1;
            end
            else if (pos_eff >= 16'd4)
            begin
                pred_next       = pred_b;
                idx_next        = idx_b;
                r0.sample       = pred_a;
                r1.sample       = pred_b;
                r1.end_of_block = last;
                r1.end_of_run   = 1'b1;
                nres            = 2'd2;
            end
        end
    end

    imab_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .load_cnt   (nres),
        .load_r0    (r0),
        .load_r1    (r1),
        .pop        (pop),
        .can_load   (can_load),
        .head_valid (head_valid),
        .head       (head),
        .cnt        (qcnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            bpb_reg    <= 16'd256;
            pos_reg    <= 16'd0;
            pred_reg   <= 16'sd0;
            idx_reg    <= 7'd0;
            hlow_reg   <= 8'd0;
            err_reg    <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                ivalid_reg <= 1'b1;
            end
            else if (take)
            begin
                ivalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                bpb_reg <= cfg_data;
            end
            if (take)
            begin
                pos_reg  <= pos_next;
                pred_reg <= pred_next;
                idx_reg  <= idx_next;
                hlow_reg <= hlow_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            idata_reg <= data_byte;
            isos_reg  <= start_of_stream;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IndexMax)
        else $error("step index left its range");

    a_bad_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_index) |-> (end_of_run && !end_of_block && sample == 16'sd0))
        else $error("error result has wrong flags");

    a_pair_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (take && nres == 2'd2) |=> (qcnt == 2'd2))
        else $error("data byte did not queue two results");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (take && err_reg && !isos_reg) |=> (qcnt == 2'd0))
        else $error("result produced while error is held");
`endif

endmodule
